/* hdl/gprx_pkg.sv */
// package for the gamepad radio frame router
// holds configuration types, register indexes, field widths and the button remap table
// no dependencies
package gprx_pkg;

   localparam int HOP_CHANNELS = 4;
   localparam int HOP_W        = 2;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_COMBO_MASK    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD_TICKS    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELEASE_TICKS = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOP_TABLE     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_EMPTY_LIMIT   = 3'd4;

   localparam logic [15:0] RST_COMBO_MASK    = 16'h1820;
   localparam logic [15:0] RST_HOLD_TICKS    = 16'd1500;
   localparam logic [15:0] RST_RELEASE_TICKS = 16'd400;
   localparam logic [31:0] RST_HOP_TABLE     = 32'h4F31_1D04;
   localparam logic [1:0]  RST_EMPTY_LIMIT   = 2'd2;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 48;

   localparam int NUM_BUTTONS = 12;

   localparam logic [3:0] HAT_CENTRE     = 4'd0;
   localparam logic [3:0] HAT_UP         = 4'd1;
   localparam logic [3:0] HAT_UP_RIGHT   = 4'd2;
   localparam logic [3:0] HAT_RIGHT      = 4'd3;
   localparam logic [3:0] HAT_DOWN_RIGHT = 4'd4;
   localparam logic [3:0] HAT_DOWN       = 4'd5;
   localparam logic [3:0] HAT_DOWN_LEFT  = 4'd6;
   localparam logic [3:0] HAT_LEFT       = 4'd7;
   localparam logic [3:0] HAT_UP_LEFT    = 4'd8;

   typedef logic [15:0] button_src_type [NUM_BUTTONS];

   localparam button_src_type BUTTON_SRC = '{
      16'h0080, 16'h0040, 16'h4000, 16'h2000, 16'h0800, 16'h1000,
      16'h0020, 16'h0010, 16'h0008, 16'h0004, 16'h0002, 16'h0001
   };

   typedef struct packed {
      logic [15:0] combo_mask;
      logic [15:0] hold_ticks;
      logic [15:0] release_ticks;
      logic [31:0] hop_table;
      logic [1:0]  empty_limit;
   } cfg_type;

   typedef struct packed {
      logic [15:0]            raw;
      logic                   player;
      logic [NUM_BUTTONS-1:0] buttons;
      logic [3:0]             hat;
      logic                   combo_match;
   } dec_type;

endpackage

/* hdl/gprx_csr.sv */
// configuration registers of the gamepad radio frame router
// plain write port, no read-back; depends on gprx_pkg
module gprx_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [gprx_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [gprx_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output gprx_pkg::cfg_type                  cfg
);

   gprx_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            gprx_pkg::CSR_COMBO_MASK:    cfg_in.combo_mask    = csr_wdata[15:0];
            gprx_pkg::CSR_HOLD_TICKS:    cfg_in.hold_ticks    = csr_wdata[15:0];
            gprx_pkg::CSR_RELEASE_TICKS: cfg_in.release_ticks = csr_wdata[15:0];
            gprx_pkg::CSR_HOP_TABLE:     cfg_in.hop_table     = csr_wdata[31:0];
            gprx_pkg::CSR_EMPTY_LIMIT:   cfg_in.empty_limit   = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.combo_mask    <= gprx_pkg::RST_COMBO_MASK;
         cfg_ff.hold_ticks    <= gprx_pkg::RST_HOLD_TICKS;
         cfg_ff.release_ticks <= gprx_pkg::RST_RELEASE_TICKS;
         cfg_ff.hop_table     <= gprx_pkg::RST_HOP_TABLE;
         cfg_ff.empty_limit   <= gprx_pkg::RST_EMPTY_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/gprx_decode.sv */
// packet decode: raw word, player choice, button remap, hat code and combo match
// purely combinational; depends on gprx_pkg
module gprx_decode (
   input  logic [2:0]         pipe_number,
   input  logic [7:0]         byte_high,
   input  logic [7:0]         byte_low_inverted,
   input  logic [15:0]        combo_mask,
   output gprx_pkg::dec_type  dec
);

   logic [15:0] raw;
   logic        up, dn, lf, rt;

   assign raw = {byte_high, ~byte_low_inverted};
   assign up  = raw[3];
   assign dn  = raw[2];
   assign lf  = raw[1];
   assign rt  = raw[0];

   always_comb begin
      dec.raw = raw;

      case (pipe_number)
         3'd0:    dec.player = 1'b0;
         3'd1:    dec.player = 1'b1;
         default: dec.player = raw[15];
      endcase

      for (int i = 0; i < gprx_pkg::NUM_BUTTONS; i++) begin
         dec.buttons[i] = |(raw & gprx_pkg::BUTTON_SRC[i]);
      end

      if (up && rt)      dec.hat = gprx_pkg::HAT_UP_RIGHT;
      else if (rt && dn) dec.hat = gprx_pkg::HAT_DOWN_RIGHT;
      else if (dn && lf) dec.hat = gprx_pkg::HAT_DOWN_LEFT;
      else if (lf && up) dec.hat = gprx_pkg::HAT_UP_LEFT;
      else if (up)       dec.hat = gprx_pkg::HAT_UP;
      else if (rt)       dec.hat = gprx_pkg::HAT_RIGHT;
      else if (dn)       dec.hat = gprx_pkg::HAT_DOWN;
      else if (lf)       dec.hat = gprx_pkg::HAT_LEFT;
      else               dec.hat = gprx_pkg::HAT_CENTRE;

      dec.combo_match = ((raw & combo_mask) == combo_mask);
   end

endmodule

/* hdl/gamepad_rx_frame_router_unit.sv */
// top level of the gamepad radio frame router
// input register, decode, router state and result register; depends on gprx_pkg,
// gprx_csr and gprx_decode
//
// usage: one poll result per req transaction (tuser = packet flag, 0 for an empty poll),
// one result per rsp transaction carrying the channel in use, an optional gamepad
// report (tuser = report valid) and the mode-switch request.
// a poll is captured in an input register, decoded and the router state updated as the
// result moves into the result register; throughput, set by the single state update
// path (hop index, empty count, last words, combo timer), is one poll per cycle unless
// a result waits on a low rsp_tready. while such a result waits, one further poll is
// still taken into the input register; req_tready falls only when both registers hold
// an item. the user must see that configuration is written through csr_we, csr_addr
// and csr_wdata only while the block is idle; the block itself does not enforce it.
// a synchronous reset empties both registers, restores the register defaults, clears
// the hop index, the empty count, the per-player valid flags and the combo timer.
module gamepad_rx_frame_router_unit (
   input  logic                                clock,
   input  logic                                reset,
   // mode
   input  logic                                req_tuser,
   // pipe_number, byte_high, byte_low_inverted, host_ready, now_tick, zero fill
   input  logic [gprx_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // report_valid
   output logic                                rsp_tuser,
   // channel_number, report_player, button_bits, hat_code, raw_word, switch_request,
   // zero fill
   output logic [gprx_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [gprx_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [gprx_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   gprx_pkg::cfg_type cfg;
   gprx_pkg::dec_type dec;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_mode_ff;
   logic [2:0]  s1_pipe_ff;
   logic [7:0]  s1_hi_ff;
   logic [7:0]  s1_lo_ff;
   logic [1:0]  s1_ready_ff;
   logic [31:0] s1_now_ff;

   logic        out_valid_ff, out_valid_in;
   logic        out_rvalid_ff, out_rvalid_in;
   logic [gprx_pkg::RSP_TDATA_W-1:0] out_data_ff, out_data_in;

   logic [gprx_pkg::HOP_W-1:0] hop_index_ff, hop_index_in;
   logic [1:0]  empty_count_ff, empty_count_in;
   logic [15:0] last_raw_ff [2];
   logic [1:0]  last_valid_ff, last_valid_in;
   logic        combo_active_ff, combo_active_in;
   logic [31:0] combo_start_ff, combo_start_in;
   logic [31:0] combo_seen_ff, combo_seen_in;

   logic        push, accept;
   logic        hop, changed, report;
   logic [1:0]  empty_inc;
   logic [31:0] seen_gap, start_gap;
   logic        switch_req;
   logic [7:0]  channel;
   logic [31:0] hop_shifted;

   gprx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gprx_decode u_decode (
      .pipe_number       (s1_pipe_ff),
      .byte_high         (s1_hi_ff),
      .byte_low_inverted (s1_lo_ff),
      .combo_mask        (cfg.combo_mask),
      .dec               (dec)
   );

   assign push       = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || push;
   assign accept     = req_tvalid && req_tready;

   assign s1_valid_in  = accept ? 1'b1 : (push ? 1'b0 : s1_valid_ff);
   assign out_valid_in = push ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_comb begin
      empty_inc      = empty_count_ff + 2'd1;
      hop            = 1'b0;
      empty_count_in = empty_count_ff;
      last_valid_in  = last_valid_ff;
      changed        = 1'b0;
      report         = 1'b0;
      combo_active_in = combo_active_ff;
      combo_start_in  = combo_start_ff;
      combo_seen_in   = combo_seen_ff;
      switch_req      = 1'b0;

      if (s1_mode_ff) begin
         empty_count_in = 2'd0;
         hop            = 1'b1;
         changed = !last_valid_ff[dec.player] || (last_raw_ff[dec.player] != dec.raw);
         report  = changed && s1_ready_ff[dec.player];
         if (changed) begin
            last_valid_in[dec.player] = 1'b1;
         end
         if (dec.combo_match) begin
            if (!combo_active_ff) begin
               combo_start_in = s1_now_ff;
            end
            combo_active_in = 1'b1;
            combo_seen_in   = s1_now_ff;
         end else begin
            combo_active_in = 1'b0;
         end
      end else begin
         empty_count_in = empty_inc;
         if (empty_inc >= cfg.empty_limit) begin
            empty_count_in = 2'd0;
            hop            = 1'b1;
         end
      end

      seen_gap  = s1_now_ff - combo_seen_in;
      start_gap = s1_now_ff - combo_start_in;
      if (combo_active_in) begin
         if (seen_gap > {16'd0, cfg.release_ticks}) begin
            combo_active_in = 1'b0;
         end else if (start_gap > {16'd0, cfg.hold_ticks}) begin
            switch_req      = 1'b1;
            combo_active_in = 1'b0;
         end
      end

      if (!hop) begin
         hop_index_in = hop_index_ff;
      end else if (hop_index_ff == gprx_pkg::HOP_W'(gprx_pkg::HOP_CHANNELS - 1)) begin
         hop_index_in = '0;
      end else begin
         hop_index_in = hop_index_ff + gprx_pkg::HOP_W'(1);
      end

      hop_shifted = cfg.hop_table >> {hop_index_in, 3'b000};
      channel     = hop_shifted[7:0];

      out_rvalid_in = report;
      out_data_in   = '0;
      out_data_in[7:0] = channel;
      if (report) begin
         out_data_in[8]     = dec.player;
         out_data_in[20:9]  = dec.buttons;
         out_data_in[24:21] = dec.hat;
         out_data_in[40:25] = dec.raw;
      end
      out_data_in[41] = switch_req;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         hop_index_ff    <= '0;
         empty_count_ff  <= 2'd0;
         last_valid_ff   <= 2'b00;
         combo_active_ff <= 1'b0;
         combo_start_ff  <= 32'd0;
         combo_seen_ff   <= 32'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (push) begin
            hop_index_ff    <= hop_index_in;
            empty_count_ff  <= empty_count_in;
            last_valid_ff   <= last_valid_in;
            combo_active_ff <= combo_active_in;
            combo_start_ff  <= combo_start_in;
            combo_seen_ff   <= combo_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff  <= req_tuser;
         s1_pipe_ff  <= req_tdata[2:0];
         s1_hi_ff    <= req_tdata[10:3];
         s1_lo_ff    <= req_tdata[18:11];
         s1_ready_ff <= req_tdata[20:19];
         s1_now_ff   <= req_tdata[52:21];
      end
      if (push) begin
         out_rvalid_ff <= out_rvalid_in;
         out_data_ff   <= out_data_in;
         if (s1_mode_ff && changed) begin
            last_raw_ff[dec.player] <= dec.raw;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_rvalid_ff;
   assign rsp_tdata  = out_data_ff;

   // report fields stay zero without a report
   a_no_report_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[40:8] == 33'd0))
      else $error("report fields set without report_valid");

   // a switch request always ends the hold
   a_switch_ends_hold : assert property (@(posedge clock) disable iff (reset)
      (push && switch_req) |=> !combo_active_ff)
      else $error("combo hold still active after switch request");

   // hop index stays inside the hop table
   a_hop_range : assert property (@(posedge clock) disable iff (reset)
      hop_index_ff <= gprx_pkg::HOP_W'(gprx_pkg::HOP_CHANNELS - 1))
      else $error("hop index out of range");

   // the empty count clears before it can reach three
   a_empty_count : assert property (@(posedge clock) disable iff (reset)
      empty_count_ff != 2'd3)
      else $error("empty count reached three");

   // a packet for player 0 leaves player 0 marked as seen
   a_player_seen : assert property (@(posedge clock) disable iff (reset)
      (push && s1_mode_ff && !dec.player) |=> last_valid_ff[0])
      else $error("player 0 not marked after packet");

   // no input register overwrite while an item is held and not moving on
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !push) |-> !accept)
      else $error("input register overwritten");

endmodule
